@@ rtl/ipv4ac_pkg.sv @@
package ipv4ac_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int ADDR_W      = 32;
  localparam int CAT_W       = 3;

  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;

  localparam logic [CAT_W-1:0] CAT_FAR       = 3'd0;
  localparam logic [CAT_W-1:0] CAT_NEAR      = 3'd1;
  localparam logic [CAT_W-1:0] CAT_LOCAL     = 3'd2;
  localparam logic [CAT_W-1:0] CAT_BROADCAST = 3'd3;
  localparam logic [CAT_W-1:0] CAT_LOOPBACK  = 3'd4;

  localparam logic [7:0]        LOOP_NET  = 8'h7f;
  localparam logic [ADDR_W-1:0] LOOP_LOW  = 32'h7f00_0000;
  localparam logic [ADDR_W-1:0] LOOP_HIGH = 32'h7fff_ffff;

  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              done;
    logic [CAT_W-1:0]  cat;
    logic              near;
  } token_t;

endpackage

@@ rtl/ipv4_address_classifier_top.sv @@
// Each accepted item passes through the 16 cell registers and then the output register to the result.
// Throughput: one item per cycle; the whole cell chain stalls while a result waits.
// Each item walks the chain one cell per cycle; each cell holds one table entry.
// Reset (rst_n, synchronous, active low) clears num_entries and all in-flight items.
// Table entries are not cleared by reset and are undefined until written.
module ipv4_address_classifier_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [ipv4ac_pkg::IDX_W-1:0]      in_entry_index,
  input  logic [ipv4ac_pkg::ADDR_W-1:0]     in_ip_addr,
  input  logic [ipv4ac_pkg::ADDR_W-1:0]     in_net_mask,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ipv4ac_pkg::CAT_W-1:0]      out_category,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ipv4ac_pkg::CNT_W-1:0]      cfg_num_entries
);
  import ipv4ac_pkg::*;

  logic              adv;
  logic [CNT_W-1:0]  num_entries_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CAT_W-1:0]  out_category_r;
  logic [CAT_W-1:0]  out_category_nxt;
  logic              is_loop;
  token_t            tok [TABLE_DEPTH+1];

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign is_loop   = in_ip_addr[ADDR_W-1:ADDR_W-8] == LOOP_NET;

  always_comb begin
    tok[0].valid = in_valid;
    tok[0].cmd   = in_cmd;
    tok[0].idx   = in_entry_index;
    tok[0].addr  = in_ip_addr;
    tok[0].mask  = in_net_mask;
    tok[0].near  = 1'b0;
    tok[0].done  = (in_cmd == CMD_WRITE) || is_loop;
    if (in_cmd == CMD_WRITE) begin
      tok[0].cat = CAT_FAR;
    end else if ((in_ip_addr == LOOP_LOW) || (in_ip_addr == LOOP_HIGH)) begin
      tok[0].cat = CAT_BROADCAST;
    end else begin
      tok[0].cat = CAT_LOOPBACK;
    end
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    ipv4ac_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .cell_idx    (IDX_W'(k)),
      .num_entries (num_entries_r),
      .tok_in      (tok[k]),
      .tok_out     (tok[k+1])
    );
  end

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_category_nxt = out_category_r;
    if (adv) begin
      out_valid_nxt = tok[TABLE_DEPTH].valid;
      if (tok[TABLE_DEPTH].done) begin
        out_category_nxt = tok[TABLE_DEPTH].cat;
      end else if (tok[TABLE_DEPTH].near) begin
        out_category_nxt = CAT_NEAR;
      end else begin
        out_category_nxt = CAT_FAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_entries_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_entries_r <= cfg_num_entries;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_category_r <= out_category_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_category = out_category_r;

  a_cat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_category <= CAT_LOOPBACK)
    else $error("category code out of range");

  a_loop_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_CLASSIFY) && is_loop |=> tok[1].done && tok[1].valid)
    else $error("loopback item not resolved at chain entry");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_WRITE) |=> tok[1].done && (tok[1].cat == CAT_FAR))
    else $error("write item entered chain without a zero result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tok[TABLE_DEPTH].valid))
    else $error("chain moved while output stalled");

endmodule

@@ rtl/ipv4ac_cell.sv @@
module ipv4ac_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [ipv4ac_pkg::IDX_W-1:0] cell_idx,
  input  logic [ipv4ac_pkg::CNT_W-1:0] num_entries,
  input  ipv4ac_pkg::token_t       tok_in,
  output ipv4ac_pkg::token_t       tok_out
);
  import ipv4ac_pkg::*;

  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] mask_r;
  logic              valid_r;
  token_t            tok_r;
  token_t            tok_nxt;
  logic              active;
  logic              wr_hit;
  logic [ADDR_W-1:0] net;
  logic [ADDR_W-1:0] bcast;

  assign active = CNT_W'(cell_idx) < num_entries;
  assign wr_hit = adv && tok_in.valid && (tok_in.cmd == CMD_WRITE) && (tok_in.idx == cell_idx);
  assign net    = addr_r & mask_r;
  assign bcast  = net | ~mask_r;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && (tok_in.cmd == CMD_CLASSIFY) && !tok_in.done && active) begin
      if (tok_in.addr == addr_r) begin
        tok_nxt.done = 1'b1;
        tok_nxt.cat  = CAT_LOCAL;
      end else if ((tok_in.addr == net) || (tok_in.addr == bcast)) begin
        tok_nxt.done = 1'b1;
        tok_nxt.cat  = CAT_BROADCAST;
      end else if ((tok_in.addr & mask_r) == net) begin
        tok_nxt.near = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
    if (wr_hit) begin
      addr_r <= tok_in.addr;
      mask_r <= tok_in.mask;
    end
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = valid_r;
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tok_in.valid && tok_in.done |=> tok_r.done && (tok_r.cat == $past(tok_in.cat)))
    else $error("finished item lost its result in cell");

  a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(addr_r) && $stable(mask_r))
    else $error("entry changed while chain stalled");

  a_inactive_pass: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tok_in.valid && !active |=>
      (tok_r.done == $past(tok_in.done)) && (tok_r.near == $past(tok_in.near)))
    else $error("cell past the count changed an item");

endmodule

@@ sim/ipv4_address_classifier_top_tb.sv @@
module ipv4_address_classifier_top_tb;
  import ipv4ac_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 200;
  localparam int TAIL_CYCLES  = 40;

  class category_scoreboard;
    logic [ADDR_W-1:0] ent_addr [TABLE_DEPTH];
    logic [ADDR_W-1:0] ent_mask [TABLE_DEPTH];
    logic [CNT_W-1:0]  live_count;
    logic [CAT_W-1:0]  expected_q [$];
    int unsigned       errors;
    int unsigned       results_seen;
    int unsigned       writes_seen;
    int unsigned       lookups_seen;
    int unsigned       cat_seen [5];

    function new();
      live_count   = '0;
      errors       = 0;
      results_seen = 0;
      writes_seen  = 0;
      lookups_seen = 0;
      foreach (cat_seen[i]) cat_seen[i] = 0;
      foreach (ent_addr[i]) begin
        ent_addr[i] = '0;
        ent_mask[i] = '0;
      end
    endfunction

    function void set_count(logic [CNT_W-1:0] n);
      live_count = n;
    endfunction

    function logic [CAT_W-1:0] classify_addr(logic [ADDR_W-1:0] a);
      int                lim;
      logic              near_hit;
      logic [ADDR_W-1:0] m;
      logic [ADDR_W-1:0] net;
      logic [ADDR_W-1:0] bc;
      if (a[31:24] == LOOP_NET)
        return (a == LOOP_LOW || a == LOOP_HIGH) ? CAT_BROADCAST : CAT_LOOPBACK;
      lim = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count);
      near_hit = 1'b0;
      for (int i = 0; i < lim; i++) begin
        m   = ent_mask[i];
        net = ent_addr[i] & m;
        bc  = net | ~m;
        if (a == ent_addr[i]) return CAT_LOCAL;
        if (a == net || a == bc) return CAT_BROADCAST;
        if ((a & m) == net) near_hit = 1'b1;
      end
      return near_hit ? CAT_NEAR : CAT_FAR;
    endfunction

    function void note_item(logic cmd, logic [IDX_W-1:0] idx,
                            logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] m);
      logic [CAT_W-1:0] cat;
      if (cmd == CMD_WRITE) begin
        ent_addr[idx] = a;
        ent_mask[idx] = m;
        writes_seen++;
        expected_q.push_back(CAT_FAR);  // writes answer 0
      end else begin
        cat = classify_addr(a);
        lookups_seen++;
        cat_seen[cat]++;
        expected_q.push_back(cat);
      end
    endfunction

    function void check_category(logic [CAT_W-1:0] got);
      logic [CAT_W-1:0] exp_cat;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, category %0d", $time, got);
      end else begin
        exp_cat = expected_q.pop_front();
        if (exp_cat !== got) begin
          errors++;
          $display("%0t: category mismatch: expected %0d, actual %0d", $time, exp_cat, got);
        end
      end
    endfunction
  endclass

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_ready;
  logic              in_cmd          = CMD_CLASSIFY;
  logic [IDX_W-1:0]  in_entry_index  = '0;
  logic [ADDR_W-1:0] in_ip_addr      = '0;
  logic [ADDR_W-1:0] in_net_mask     = '0;
  logic              out_valid;
  logic              out_ready       = 1'b0;
  logic [CAT_W-1:0]  out_category;
  logic              cfg_valid       = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_num_entries = '0;

  category_scoreboard sb = new();
  bit          bursts_on   = 1'b1;
  int unsigned items_sent  = 0;
  int unsigned cfg_writes  = 0;
  int          rx_hold     = 0;
  int          quiet_cycles = 0;

  ipv4_address_classifier_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_entry_index  (in_entry_index),
    .in_ip_addr      (in_ip_addr),
    .in_net_mask     (in_net_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_category    (out_category),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_num_entries (cfg_num_entries)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 9) == 0) begin
      rx_hold = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_item(in_cmd, in_entry_index, in_ip_addr, in_net_mask);
    if (rst_n && out_valid && out_ready)
      sb.check_category(out_category);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] prefix_mask(int len);
    return (len == 0) ? '0 : (32'hffff_ffff << (32 - len));
  endfunction

  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] m);
    int gap;
    gap = (bursts_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_entry_index <= idx;
    in_ip_addr     <= a;
    in_net_mask    <= m;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.results_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] n);
    cfg_valid       <= 1'b1;
    cfg_num_entries <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_count(n);
    cfg_writes++;
  endtask

  task automatic random_item();
    int                r;
    int                n_eff;
    int                j;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] net;
    r = $urandom_range(0, 99);
    n_eff = (sb.live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.live_count);
    if (r < 10) begin
      m = ($urandom_range(0, 3) == 0) ? $urandom : prefix_mask($urandom_range(0, 32));
      send_item(CMD_WRITE, IDX_W'($urandom), $urandom, m);
    end else if (n_eff == 0 || r < 22) begin
      case ($urandom_range(0, 3))
        0:       a = LOOP_LOW;
        1:       a = LOOP_HIGH;
        2:       a = {LOOP_NET, 24'($urandom)};
        default: a = $urandom;
      endcase
      send_item(CMD_CLASSIFY, IDX_W'($urandom), a, $urandom);
    end else begin
      j   = $urandom_range(0, n_eff - 1);
      m   = sb.ent_mask[j];
      net = sb.ent_addr[j] & m;
      case ($urandom_range(0, 4))
        0:       a = sb.ent_addr[j];
        1:       a = net;
        2:       a = net | ~m;
        3:       a = net | ($urandom & ~m);
        default: a = sb.ent_addr[j] ^ (32'h1 << $urandom_range(0, 31));
      endcase
      send_item(CMD_CLASSIFY, IDX_W'($urandom), a, $urandom);
    end
  endtask

  int          prefix_lens [TABLE_DEPTH] = '{32, 31, 8, 16, 24, 30, 1, 12,
                                             20, 28, 4, 25, 17, 9, 3, 0};
  logic [CNT_W-1:0] phase_counts [8];
  logic [ADDR_W-1:0] net2;

  initial begin
    phase_counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd5, 5'($urandom_range(0, 31)), 5'd16};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: loopback net, its two broadcast addresses and two addresses outside it
    write_count(5'd0);
    send_item(CMD_CLASSIFY, 4'h0, LOOP_LOW, 32'h0);
    send_item(CMD_CLASSIFY, 4'hf, LOOP_HIGH, 32'hffff_ffff);
    send_item(CMD_CLASSIFY, 4'h5, 32'h7f80_0001, 32'ha5a5_a5a5);
    send_item(CMD_CLASSIFY, 4'ha, 32'h0000_0000, 32'h5a5a_5a5a);
    send_item(CMD_CLASSIFY, 4'h3, 32'hffff_ffff, 32'h0);

    // fill every slot before any count reaches it
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(CMD_WRITE, IDX_W'(i), $urandom, prefix_mask(prefix_lens[i]));
    drain_results();
    write_count(5'd16);

    net2 = sb.ent_addr[2] & sb.ent_mask[2];
    send_item(CMD_CLASSIFY, IDX_W'($urandom), sb.ent_addr[0], $urandom);
    send_item(CMD_CLASSIFY, IDX_W'($urandom), net2, $urandom);
    send_item(CMD_CLASSIFY, IDX_W'($urandom), net2 | ~sb.ent_mask[2], $urandom);
    send_item(CMD_CLASSIFY, IDX_W'($urandom), net2 | 32'h0000_1234, $urandom);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain_results();
        write_count(phase_counts[p]);
      end
      if (p == 7) bursts_on = 1'b0;
      repeat (PHASE_ITEMS) random_item();
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.expected_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
    end
    $display("%0d table writes and %0d lookups over %0d table-size settings",
             sb.writes_seen, sb.lookups_seen, cfg_writes);
    $display("lookups: far %0d, near %0d, local %0d, broadcast %0d, loopback %0d",
             sb.cat_seen[CAT_FAR], sb.cat_seen[CAT_NEAR], sb.cat_seen[CAT_LOCAL],
             sb.cat_seen[CAT_BROADCAST], sb.cat_seen[CAT_LOOPBACK]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
